[rtl/ttb_pkg.sv]
// Shared types and constants for the triangle tile binner.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
package ttb_pkg;

    localparam int DEF_MAX_GRID_COLS = 64;
    localparam int DEF_MAX_GRID_ROWS = 64;
    localparam int DEF_LIST_DEPTH    = 8;

    localparam logic [12:0] SCREEN_W_RESET  = 13'd640;
    localparam logic [12:0] SCREEN_H_RESET  = 13'd480;
    localparam logic [8:0]  TILE_SIZE_RESET = 9'd16;

    // Divider operand widths.
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = 9;

    // Number of divisions per triangle: two grid sizes and four box bounds.
    localparam int NUM_DIVS = 6;

    typedef enum logic [1:0] {
        MODE_BIN   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } ttb_mode_t;

    typedef enum logic [1:0] {
        CFG_SCREEN_W  = 2'd0,
        CFG_SCREEN_H  = 2'd1,
        CFG_TILE_SIZE = 2'd2,
        CFG_UNUSED    = 2'd3
    } ttb_cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_BOX,
        S_T_RD,
        S_T_WR,
        S_RQ,
        S_DONE
    } ttb_state_t;

    // Divider control and status.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } ttb_div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } ttb_div_rsp_t;

endpackage

[rtl/ttb_divider.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ttb_pkg for the request and response structs.
`timescale 1ns / 1ps
module ttb_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ttb_pkg::ttb_div_req_t req,
    output ttb_pkg::ttb_div_rsp_t rsp
);
    import ttb_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   shifted;
    logic                 fits;

    // Trial subtraction of the divisor from the shifted remainder.
    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            rem_reg <= fits ? DIV_DEN_W'(shifted - {1'b0, den_reg})
                            : shifted[DIV_DEN_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

[rtl/ttb_count_ram.sv]
// Per-tile list count memory, one write and one registered read port.
// Depends on ttb_pkg only for the house import convention.
`timescale 1ns / 1ps
module ttb_count_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    import ttb_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ttb_cmd_ram.sv]
// Command store: pipeline id and data index per list slot.
// Depends on ttb_pkg only for the house import convention.
`timescale 1ns / 1ps
module ttb_cmd_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [47:0]       wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [47:0]       rdata
);
    import ttb_pkg::*;

    logic [47:0] mem [DEPTH];
    logic [47:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/triangle_tile_binner_top.sv]
// Triangle tile binner top level: control sequencer and datapath.
// Depends on ttb_pkg, ttb_divider, ttb_count_ram and ttb_cmd_ram.
`timescale 1ns / 1ps
// A bin request takes six serial divisions on the one-bit-per-cycle
// divider, then clips the box, then reads the count memory and writes it
// back for each covered tile (no tile if the box is empty), and loads the
// result. A read request reads the count memory and command store, then
// loads the result; a clear request sweeps the count memory one tile per
// cycle over all MAX_GRID_COLS * MAX_GRID_ROWS tiles. The same sweep
// runs after reset, during which no request is accepted; configuration
// writes are always taken. One request is processed at a time, and the next
// one is accepted while the previous result waits in the output register.
module triangle_tile_binner_top #(
    parameter int MAX_GRID_COLS = ttb_pkg::DEF_MAX_GRID_COLS,
    parameter int MAX_GRID_ROWS = ttb_pkg::DEF_MAX_GRID_ROWS,
    parameter int LIST_DEPTH    = ttb_pkg::DEF_LIST_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    // Input request channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic signed [19:0]  x0,
    input  logic signed [19:0]  y0,
    input  logic signed [19:0]  x1,
    input  logic signed [19:0]  y1,
    input  logic signed [19:0]  x2,
    input  logic signed [19:0]  y2,
    input  logic [15:0]         pipeline_id,
    input  logic [31:0]         data_index,
    input  logic [11:0]         read_tile,
    input  logic [2:0]          read_slot,
    // Result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [12:0]         tiles_covered,
    output logic [12:0]         dropped,
    output logic                entry_valid,
    output logic [15:0]         entry_pipeline_id,
    output logic [31:0]         entry_data_index,
    output logic [3:0]          list_count
);
    import ttb_pkg::*;

    localparam int NUM_TILES  = MAX_GRID_COLS * MAX_GRID_ROWS;
    localparam int NUM_SLOTS  = NUM_TILES * LIST_DEPTH;
    localparam int TILE_AW    = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
    localparam int STORE_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int COL_W      = $clog2(MAX_GRID_COLS + 1);
    localparam int ROW_W      = $clog2(MAX_GRID_ROWS + 1);
    localparam int PROD_W     = COL_W + ROW_W + 1;
    localparam int SADDR_W    = STORE_AW + 14;
    localparam int SEL_W      = $clog2(NUM_DIVS);

    // Bounds helpers on the raw signed coordinates.
    function automatic logic signed [19:0] min3(input logic signed [19:0] a,
                                                input logic signed [19:0] b,
                                                input logic signed [19:0] c);
        logic signed [19:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [19:0] max3(input logic signed [19:0] a,
                                                input logic signed [19:0] b,
                                                input logic signed [19:0] c);
        logic signed [19:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Whole-pixel magnitude: drop the four fraction bits toward zero.
    function automatic logic [DIV_NUM_W-1:0] pix_mag(input logic signed [19:0] v);
        logic [20:0] a;
        a = v[19] ? 21'(-{v[19], v}) : 21'({v[19], v});
        return a[19:4];
    endfunction

    // State and request registers
    ttb_state_t          state_reg, state_next;
    logic [1:0]          mode_reg;
    logic signed [19:0]  xa_reg, xb_reg, xc_reg, ya_reg, yb_reg, yc_reg;
    logic [15:0]         pid_reg;
    logic [31:0]         dat_reg;
    logic [11:0]         rtile_reg;
    logic [2:0]          rslot_reg;
    logic                clr_res_reg;
    logic [TILE_AW-1:0]  clr_addr_reg;

    // Configuration registers
    logic [12:0]         screen_w_reg, screen_h_reg;
    logic [8:0]          tile_size_reg;

    // Division results
    logic [SEL_W-1:0]     div_sel_reg;
    logic [DIV_NUM_W-1:0] quo_reg [NUM_DIVS];
    logic                 neg_reg [NUM_DIVS];

    // Box walk
    logic [COL_W-1:0]    gc_reg, x_lo_reg, x_hi_reg, x_reg;
    logic [ROW_W-1:0]    y_lo_reg, y_hi_reg, y_reg;
    logic [12:0]         covered_reg, dropped_reg;

    // Output registers
    logic                out_valid_reg;
    logic [12:0]         tiles_covered_reg, dropped_out_reg, list_count_pad;
    logic                entry_valid_reg;
    logic [15:0]         entry_pid_reg;
    logic [31:0]         entry_dat_reg;
    logic [3:0]          list_count_reg;

    // Combinational
    logic                in_acc, out_load;
    logic [8:0]          t_eff;
    logic [DIV_NUM_W-1:0] div_num;
    logic                div_neg;
    ttb_div_req_t        div_req;
    ttb_div_rsp_t        div_rsp;
    logic signed [17:0]  sv [NUM_DIVS];
    logic [DIV_NUM_W-1:0] gc_full, gr_full;
    logic signed [17:0]  gcm1, grm1, mnx, mxx, mny, mxy;
    logic                box_empty;
    logic [PROD_W-1:0]   tile_full;
    logic [TILE_AW-1:0]  cur_tile;
    logic                cnt_we, cnt_re, st_we, st_re;
    logic [TILE_AW-1:0]  cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
    logic [STORE_AW-1:0] st_waddr, st_raddr;
    logic [47:0]         st_rdata;
    logic                list_full, x_last, y_last;
    logic                rd_tile_ok, rd_slot_ok;

    assign in_acc    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign t_eff     = (tile_size_reg == 9'd0) ? 9'd1 : tile_size_reg;

    // Divider operand select: grid sizes first, then the four box bounds.
    always_comb
    begin
        div_num = '0;
        div_neg = 1'b0;
        case (div_sel_reg)
            SEL_W'(0): div_num = DIV_NUM_W'({1'b0, screen_w_reg} + {5'd0, t_eff} - 14'd1);
            SEL_W'(1): div_num = DIV_NUM_W'({1'b0, screen_h_reg} + {5'd0, t_eff} - 14'd1);
            SEL_W'(2):
            begin
                div_num = pix_mag(min3(xa_reg, xb_reg, xc_reg));
                div_neg = min3(xa_reg, xb_reg, xc_reg) < 0;
            end
            SEL_W'(3):
            begin
                div_num = pix_mag(max3(xa_reg, xb_reg, xc_reg));
                div_neg = max3(xa_reg, xb_reg, xc_reg) < 0;
            end
            SEL_W'(4):
            begin
                div_num = pix_mag(min3(ya_reg, yb_reg, yc_reg));
                div_neg = min3(ya_reg, yb_reg, yc_reg) < 0;
            end
            SEL_W'(5):
            begin
                div_num = pix_mag(max3(ya_reg, yb_reg, yc_reg));
                div_neg = max3(ya_reg, yb_reg, yc_reg) < 0;
            end
            default:
            begin
                div_num = '0;
                div_neg = 1'b0;
            end
        endcase
    end

    assign div_req.start = (state_reg == S_DIV_GO);
    assign div_req.num   = div_num;
    assign div_req.den   = t_eff;

    ttb_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Signed quotients and clipping of the box against the grid.
    always_comb
    begin
        for (int i = 0; i < NUM_DIVS; i++)
        begin
            sv[i] = neg_reg[i] ? -$signed({2'b00, quo_reg[i]})
                               : $signed({2'b00, quo_reg[i]});
        end
        gc_full   = (quo_reg[0] > DIV_NUM_W'(MAX_GRID_COLS)) ? DIV_NUM_W'(MAX_GRID_COLS)
                                                              : quo_reg[0];
        gr_full   = (quo_reg[1] > DIV_NUM_W'(MAX_GRID_ROWS)) ? DIV_NUM_W'(MAX_GRID_ROWS)
                                                              : quo_reg[1];
        gcm1      = $signed({2'b00, gc_full}) - 18'sd1;
        grm1      = $signed({2'b00, gr_full}) - 18'sd1;
        mnx       = sv[2][17] ? 18'sd0 : sv[2];
        mny       = sv[4][17] ? 18'sd0 : sv[4];
        mxx       = (sv[3] > gcm1) ? gcm1 : sv[3];
        mxy       = (sv[5] > grm1) ? grm1 : sv[5];
        box_empty = (mxx < mnx) || (mxy < mny);
    end

    // Tile number of the current box position.
    assign tile_full = PROD_W'(y_reg) * PROD_W'(gc_reg) + PROD_W'(x_reg);
    assign cur_tile  = TILE_AW'(tile_full);
    assign list_full = cnt_rdata >= CNT_W'(LIST_DEPTH);
    assign x_last    = (x_reg == x_hi_reg);
    assign y_last    = (y_reg == y_hi_reg);

    // Memory port control
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = cur_tile;
        cnt_wdata = CNT_W'(cnt_rdata + 1'b1);
        cnt_re    = 1'b0;
        cnt_raddr = cur_tile;
        st_we     = 1'b0;
        st_re     = 1'b0;
        st_waddr  = STORE_AW'(SADDR_W'(cur_tile) * SADDR_W'(LIST_DEPTH)
                              + SADDR_W'(cnt_rdata));
        st_raddr  = STORE_AW'(SADDR_W'(rtile_reg) * SADDR_W'(LIST_DEPTH)
                              + SADDR_W'(rslot_reg));
        unique case (state_reg)
            S_CLR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_addr_reg;
                cnt_wdata = '0;
            end
            S_T_RD:
            begin
                cnt_re = 1'b1;
            end
            S_T_WR:
            begin
                cnt_we = !list_full;
                st_we  = !list_full;
            end
            S_RQ:
            begin
                cnt_re    = 1'b1;
                cnt_raddr = TILE_AW'(rtile_reg);
                st_re     = 1'b1;
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    ttb_count_ram #(
        .DEPTH  (NUM_TILES),
        .ADDR_W (TILE_AW),
        .DATA_W (CNT_W)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    ttb_cmd_ram #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (STORE_AW)
    ) u_cmd_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata ({pid_reg, dat_reg}),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_addr_reg == TILE_AW'(NUM_TILES - 1))
                begin
                    state_next = clr_res_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (mode)
                        MODE_BIN:   state_next = S_DIV_GO;
                        MODE_CLEAR: state_next = S_CLR;
                        MODE_READ:  state_next = S_RQ;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (div_sel_reg == SEL_W'(NUM_DIVS - 1)) ? S_BOX : S_DIV_GO;
                end
            end
            S_BOX:      state_next = box_empty ? S_DONE : S_T_RD;
            S_T_RD:     state_next = S_T_WR;
            S_T_WR:     state_next = (x_last && y_last) ? S_DONE : S_T_RD;
            S_RQ:       state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_res_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            div_sel_reg   <= '0;
            out_valid_reg <= 1'b0;
            screen_w_reg  <= SCREEN_W_RESET;
            screen_h_reg  <= SCREEN_H_RESET;
            tile_size_reg <= TILE_SIZE_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SCREEN_W:  screen_w_reg  <= cfg_data;
                    CFG_SCREEN_H:  screen_h_reg  <= cfg_data;
                    CFG_TILE_SIZE: tile_size_reg <= cfg_data[8:0];
                    default:       tile_size_reg <= tile_size_reg;
                endcase
            end

            if (state_reg == S_CLR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            else
            begin
                clr_addr_reg <= '0;
            end

            if (in_acc)
            begin
                clr_res_reg <= (mode == MODE_CLEAR);
                div_sel_reg <= '0;
            end
            else if (state_reg == S_DIV_WAIT && div_rsp.done)
            begin
                div_sel_reg <= div_sel_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Read result checks
    assign rd_tile_ok = 32'(rtile_reg) < 32'(NUM_TILES);
    assign rd_slot_ok = (32'(rslot_reg) < 32'(cnt_rdata))
                        && (32'(rslot_reg) < 32'(LIST_DEPTH));

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg  <= mode;
            xa_reg    <= x0;
            ya_reg    <= y0;
            xb_reg    <= x1;
            yb_reg    <= y1;
            xc_reg    <= x2;
            yc_reg    <= y2;
            pid_reg   <= pipeline_id;
            dat_reg   <= data_index;
            rtile_reg <= read_tile;
            rslot_reg <= read_slot;
        end

        if (state_reg == S_DIV_WAIT && div_rsp.done)
        begin
            quo_reg[div_sel_reg] <= div_rsp.quo;
            neg_reg[div_sel_reg] <= div_neg;
        end

        // Latch the clipped box and start the walk at its corner.
        if (state_reg == S_BOX)
        begin
            gc_reg      <= COL_W'(gc_full);
            x_lo_reg    <= COL_W'(mnx);
            x_hi_reg    <= COL_W'(mxx);
            y_lo_reg    <= ROW_W'(mny);
            y_hi_reg    <= ROW_W'(mxy);
            x_reg       <= COL_W'(mnx);
            y_reg       <= ROW_W'(mny);
            covered_reg <= '0;
            dropped_reg <= '0;
        end

        // Append to one tile list and step row-major through the box.
        if (state_reg == S_T_WR)
        begin
            covered_reg <= covered_reg + 1'b1;
            if (list_full)
            begin
                dropped_reg <= dropped_reg + 1'b1;
            end
            if (x_last)
            begin
                x_reg <= x_lo_reg;
                y_reg <= y_reg + 1'b1;
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
            end
        end

        // Result assembly; fields a mode does not produce are zero.
        if (out_load)
        begin
            tiles_covered_reg <= '0;
            dropped_out_reg   <= '0;
            entry_valid_reg   <= 1'b0;
            entry_pid_reg     <= '0;
            entry_dat_reg     <= '0;
            list_count_reg    <= '0;
            if (!clr_res_reg && mode_reg == MODE_BIN)
            begin
                tiles_covered_reg <= covered_reg;
                dropped_out_reg   <= dropped_reg;
            end
            else if (!clr_res_reg && mode_reg == MODE_READ && rd_tile_ok)
            begin
                list_count_reg <= 4'(cnt_rdata);
                if (rd_slot_ok)
                begin
                    entry_valid_reg <= 1'b1;
                    entry_pid_reg   <= st_rdata[47:32];
                    entry_dat_reg   <= st_rdata[31:0];
                end
            end
        end
    end

    // An empty box never enters the walk, so the counters start from zero.
    assign list_count_pad = 13'(list_count_reg);

    assign out_valid         = out_valid_reg;
    assign tiles_covered     = tiles_covered_reg;
    assign dropped           = dropped_out_reg;
    assign entry_valid       = entry_valid_reg;
    assign entry_pipeline_id = entry_pid_reg;
    assign entry_data_index  = entry_dat_reg;
    assign list_count        = list_count_pad[3:0];

    // A list count written back never exceeds the list depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (32'(cnt_wdata) <= 32'(LIST_DEPTH)))
        else $error("list count written beyond list depth");

    // The command store is written only while appending a tile.
    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> (state_reg == S_T_WR) && !list_full)
        else $error("command store written outside an append");

    // After a request is taken, the block is busy on the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("second request accepted while busy");

    // The divider only reports completion while a division is awaited.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside a wait state");

endmodule

[verif/tb_triangle_tile_binner_top.sv]
// Self-checking testbench for the triangle tile binner top level.
// Depends on ttb_pkg and the triangle_tile_binner_top RTL only.
`timescale 1ns / 1ps
module tb_triangle_tile_binner_top;
    import ttb_pkg::*;

    localparam int GRID_COLS_CAP = DEF_MAX_GRID_COLS;
    localparam int GRID_ROWS_CAP = DEF_MAX_GRID_ROWS;
    localparam int DEPTH         = DEF_LIST_DEPTH;
    localparam int TILE_COUNT    = GRID_COLS_CAP * GRID_ROWS_CAP;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct {
        ttb_mode_t          mode;
        logic signed [19:0] vx[3];
        logic signed [19:0] vy[3];
        logic [15:0]        pid;
        logic [31:0]        dat;
        logic [11:0]        rtile;
        logic [2:0]         rslot;
    } bin_request_t;

    typedef struct {
        logic [12:0] covered;
        logic [12:0] drops;
        logic        evalid;
        logic [15:0] epid;
        logic [31:0] edat;
        logic [3:0]  count;
    } bin_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [12:0] cfg_data;
    logic in_valid, in_ready;
    logic [1:0] mode;
    logic signed [19:0] x0, y0, x1, y1, x2, y2;
    logic [15:0] pipeline_id;
    logic [31:0] data_index;
    logic [11:0] read_tile;
    logic [2:0] read_slot;
    logic out_valid, out_ready;
    logic [12:0] tiles_covered, dropped;
    logic entry_valid;
    logic [15:0] entry_pipeline_id;
    logic [31:0] entry_data_index;
    logic [3:0] list_count;

    // Model of the block's registers and tile lists.
    int unsigned scr_w, scr_h, tsize;
    int unsigned list_cnt[TILE_COUNT];
    logic [15:0] list_pid[TILE_COUNT*DEPTH];
    logic [31:0] list_dat[TILE_COUNT*DEPTH];
    int unsigned last_tile;

    bin_result_t expected_results[$];
    int errors = 0;
    int cycles = 0;
    bit no_gaps;

    triangle_tile_binner_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .x0(x0), .y0(y0), .x1(x1), .y1(y1), .x2(x2), .y2(y2),
        .pipeline_id(pipeline_id), .data_index(data_index),
        .read_tile(read_tile), .read_slot(read_slot),
        .out_valid(out_valid), .out_ready(out_ready),
        .tiles_covered(tiles_covered), .dropped(dropped),
        .entry_valid(entry_valid), .entry_pipeline_id(entry_pipeline_id),
        .entry_data_index(entry_data_index), .list_count(list_count)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int grid_dim(int unsigned size, int t, int cap);
        int g;
        g = (int'(size) + t - 1) / t;
        return (g > cap) ? cap : g;
    endfunction

    // Computes the result of one request and updates the tile lists.
    function automatic bin_result_t binner_predict(bin_request_t r);
        bin_result_t res;
        int t, gc, gr, mnx, mny, mxx, mxy, tile, lo, hi;
        int unsigned c;
        res = '{default: '0};
        if (r.mode == MODE_BIN)
        begin
            t  = (tsize == 0) ? 1 : int'(tsize);
            gc = grid_dim(scr_w, t, GRID_COLS_CAP);
            gr = grid_dim(scr_h, t, GRID_ROWS_CAP);
            lo = r.vx[0]; hi = r.vx[0];
            for (int i = 1; i < 3; i++)
            begin
                if (int'(r.vx[i]) < lo) lo = r.vx[i];
                if (int'(r.vx[i]) > hi) hi = r.vx[i];
            end
            mnx = (lo / 16) / t;
            mxx = (hi / 16) / t;
            lo = r.vy[0]; hi = r.vy[0];
            for (int i = 1; i < 3; i++)
            begin
                if (int'(r.vy[i]) < lo) lo = r.vy[i];
                if (int'(r.vy[i]) > hi) hi = r.vy[i];
            end
            mny = (lo / 16) / t;
            mxy = (hi / 16) / t;
            if (mnx < 0) mnx = 0;
            if (mny < 0) mny = 0;
            if (mxx > gc - 1) mxx = gc - 1;
            if (mxy > gr - 1) mxy = gr - 1;
            for (int y = mny; y <= mxy; y++)
                for (int x = mnx; x <= mxx; x++)
                begin
                    tile = y * gc + x;
                    if (tile < 0 || tile >= TILE_COUNT) continue;
                    if (res.covered == 0) last_tile = tile;
                    res.covered++;
                    c = list_cnt[tile];
                    if (c >= DEPTH)
                        res.drops++;
                    else
                    begin
                        list_pid[tile*DEPTH + c] = r.pid;
                        list_dat[tile*DEPTH + c] = r.dat;
                        list_cnt[tile] = c + 1;
                    end
                end
        end
        else if (r.mode == MODE_CLEAR)
        begin
            foreach (list_cnt[i]) list_cnt[i] = 0;
        end
        else if (r.mode == MODE_READ)
        begin
            if (r.rtile < TILE_COUNT)
            begin
                c = list_cnt[r.rtile];
                res.count = 4'(c);
                if (r.rslot < c && r.rslot < DEPTH)
                begin
                    res.evalid = 1'b1;
                    res.epid   = list_pid[r.rtile*DEPTH + r.rslot];
                    res.edat   = list_dat[r.rtile*DEPTH + r.rslot];
                end
            end
        end
        return res;
    endfunction

    // Sends one request, after a random gap unless no_gaps is set, and records its expected result.
    task automatic send_request(bin_request_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode <= r.mode;
        x0 <= r.vx[0]; y0 <= r.vy[0];
        x1 <= r.vx[1]; y1 <= r.vy[1];
        x2 <= r.vx[2]; y2 <= r.vy[2];
        pipeline_id <= r.pid;
        data_index <= r.dat;
        read_tile <= r.rtile;
        read_slot <= r.rslot;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        expected_results.insert(expected_results.size(), binner_predict(r));
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(ttb_cfg_idx_t idx, int unsigned value);
        wait_drained();
        cfg_index <= idx;
        cfg_data <= value[12:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SCREEN_W:  scr_w = value & 13'h1FFF;
            CFG_SCREEN_H:  scr_h = value & 13'h1FFF;
            CFG_TILE_SIZE: tsize = value & 9'h1FF;
            default: ;
        endcase
    endtask

    task automatic set_grid(int unsigned w, int unsigned h, int unsigned t);
        write_reg(CFG_SCREEN_W, w);
        write_reg(CFG_SCREEN_H, h);
        write_reg(CFG_TILE_SIZE, t);
    endtask

    function automatic bin_request_t make_bin(int x_a, int y_a, int x_b, int y_b,
                                              int x_c, int y_c);
        bin_request_t r;
        r.mode = MODE_BIN;
        r.vx[0] = 20'(x_a); r.vy[0] = 20'(y_a);
        r.vx[1] = 20'(x_b); r.vy[1] = 20'(y_b);
        r.vx[2] = 20'(x_c); r.vy[2] = 20'(y_c);
        r.pid = 16'($urandom);
        r.dat = $urandom;
        r.rtile = 12'($urandom);
        r.rslot = 3'($urandom);
        return r;
    endfunction

    function automatic bin_request_t make_other(ttb_mode_t m, int tile, int slot);
        bin_request_t r;
        r = make_bin($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        r.mode = m;
        r.rtile = 12'(tile);
        r.rslot = 3'(slot);
        return r;
    endfunction

    // Small triangle near the screen, occasionally a full-range one.
    function automatic bin_request_t random_triangle(bit full_range);
        int t, bx, by, span;
        bin_request_t r;
        t = (tsize == 0) ? 1 : tsize;
        span = t * 3 * 16;
        bx = ($urandom_range(0, scr_w + 32) - 16) * 16;
        by = ($urandom_range(0, scr_h + 32) - 16) * 16;
        r = make_bin(bx + $urandom_range(0, span), by + $urandom_range(0, span),
                     bx + $urandom_range(0, span), by + $urandom_range(0, span),
                     bx + $urandom_range(0, span), by + $urandom_range(0, span));
        if (full_range)
            for (int i = 0; i < 3; i++)
            begin
                r.vx[i] = 20'($urandom);
                r.vy[i] = 20'($urandom);
            end
        return r;
    endfunction

    // Mixed random traffic under the current configuration.
    task automatic random_traffic(int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                send_request(random_triangle($urandom_range(0, 99) < 3));
            else if (sel < 90)
                send_request(make_other(MODE_READ,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : last_tile,
                    $urandom_range(0, 7)));
            else if (sel < 94)
                send_request(make_other(MODE_CLEAR, $urandom, $urandom));
            else
                send_request(make_other(MODE_NOP, $urandom, $urandom));
        end
    endtask

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin
        bin_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("Unexpected result at cycle %0d", cycles);
            end
            else
            begin
                e = expected_results.pop_front();
                if (tiles_covered !== e.covered || dropped !== e.drops ||
                    entry_valid !== e.evalid || entry_pipeline_id !== e.epid ||
                    entry_data_index !== e.edat || list_count !== e.count)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: exp cov=%0d drop=%0d ev=%0d pid=%h dat=%h cnt=%0d",
                                 e.covered, e.drops, e.evalid, e.epid, e.edat, e.count,
                                 " got cov=%0d drop=%0d ev=%0d pid=%h dat=%h cnt=%0d",
                                 tiles_covered, dropped, entry_valid, entry_pipeline_id,
                                 entry_data_index, list_count);
                end
            end
        end
    end

    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Defaults after reset, fill and overflow of one list, reads around it.
    task automatic test_defaults_and_overflow();
        for (int i = 0; i < 10; i++)
            send_request(make_bin(40*16, 40*16, 41*16, 40*16, 40*16, 47*16 + 15));
        for (int s = 0; s < 8; s++)
            send_request(make_other(MODE_READ, 2*40 + 2, s));
        send_request(make_other(MODE_READ, 4095, 7));
        send_request(make_other(MODE_NOP, 0, 0));
        send_request(make_other(MODE_CLEAR, 0, 0));
        send_request(make_other(MODE_READ, 2*40 + 2, 0));
    endtask

    // Coordinate extremes, negative boxes and truncation toward zero.
    task automatic test_extremes();
        send_request(make_bin(-524288, -524288, 524287, 524287, 0, 0));
        send_request(make_bin(-524288, -524288, -524288, -524288, -17, -1));
        send_request(make_bin(-15, -15, 15, 15, -1, 255));
        send_request(make_bin(524287, 524287, 524287, 524287, 524287, 524287));
        send_request(make_bin(-256, 0, 16*17, 0, 0, 16*33));
        send_request(make_other(MODE_READ, 0, 0));
        send_request(make_other(MODE_READ, 0, 7));
    endtask

    // Register extremes, including zero tile size and zero screen.
    task automatic test_config_sweep();
        set_grid(4096, 4096, 1);
        send_request(make_bin(0, 0, 2*16, 0, 0, 2*16));
        send_request(make_bin(-524288, -524288, 524287, 524287, 0, 0));
        send_request(make_other(MODE_READ, 4095, 0));
        set_grid(1, 1, 256);
        send_request(make_bin(0, 0, 524287, 524287, 0, 0));
        send_request(make_other(MODE_READ, 0, 1));
        set_grid(0, 100, 0);
        send_request(make_bin(0, 0, 16*5, 16*5, 0, 0));
        set_grid(100, 0, 1);
        send_request(make_bin(0, 0, 16*5, 16*5, 0, 0));
        set_grid(8191, 8191, 511);
        send_request(make_bin(0, 0, 524287, 524287, 0, 0));
        send_request(make_other(MODE_CLEAR, 0, 0));
    endtask

    // Random traffic across several grids, with a gap-free stretch and a drain.
    task automatic test_random();
        set_grid(640, 480, 16);
        random_traffic(150);
        no_gaps = 1'b1;
        random_traffic(60);
        no_gaps = 1'b0;
        wait_drained();
        random_traffic(60);
        set_grid(320, 240, 32);
        random_traffic(120);
        set_grid(97, 61, 7);
        random_traffic(100);
        set_grid(4096, 4096, 256);
        random_traffic(80);
        set_grid($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 256));
        random_traffic(80);
    endtask

    initial
    begin
        no_gaps = 1'b0;
        scr_w = SCREEN_W_RESET;
        scr_h = SCREEN_H_RESET;
        tsize = TILE_SIZE_RESET;
        last_tile = 0;
        foreach (list_cnt[i]) list_cnt[i] = 0;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SCREEN_W;
        cfg_data <= '0;
        in_valid <= 1'b0;
        mode <= MODE_NOP;
        x0 <= '0; y0 <= '0; x1 <= '0; y1 <= '0; x2 <= '0; y2 <= '0;
        pipeline_id <= '0;
        data_index <= '0;
        read_tile <= '0;
        read_slot <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_and_overflow();
        test_extremes();
        test_config_sweep();
        test_random();

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
